>>> src/swma_pkg.sv
// shared constants for the selectable window moving average
`default_nettype none

package swma_pkg;

    // window lengths in samples
    localparam int WIN_SLOW = 120;
    localparam int WIN_FAST = 5;
    localparam int WIN_MID  = 80;

    // store depth default
    localparam int MAX_WINDOW_DEF = 120;

    // field widths
    localparam int SAMPLE_W  = 12;
    localparam int AVERAGE_W = 16;
    localparam int MODE_W    = 2;

    // window_mode codes (any other code selects the mid window)
    localparam logic [MODE_W-1:0] MODE_SLOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MID  = 2'd2;

    // saturation limit of the average
    localparam logic [31:0] AVG_MAX = 32'd65535;

endpackage

`default_nettype wire

>>> src/swma_store.sv
// sample ring store: one-port synchronous ram with per-entry valid bits
`default_nettype none

module swma_store
    import swma_pkg::*;
#(
    parameter int DEPTH = MAX_WINDOW_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       addr,
    input  wire logic [SAMPLE_W-1:0] wr_data,
    output logic      [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]    vld_reg;
    logic                rd_vld_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // valid bits stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[addr];
            end
        end
    end

    // never-written entry reads as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> src/swma_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module swma_div
    import swma_pkg::*;
#(
    parameter int SW = 19,
    parameter int CW = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [SW-1:0] dividend,
    input  wire logic [CW-1:0] divisor,
    output logic               done,
    output logic      [SW-1:0] quotient
);

    localparam int CNTW = $clog2(SW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   dvs_reg, dvs_next;
    logic [SW-1:0]   quo_reg, quo_next;

    logic [CW:0]     shifted;
    logic [CW:0]     diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[SW-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNTW'(SW);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CW-1:0] : shifted[CW-1:0];
            quo_next = {quo_reg[SW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> src/selectable_window_moving_average.sv
// top level: moving average over a selectable window, ring store in ram
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tdata[11:0] sample
//  m_*       out  m_tvalid / m_tready     m_tdata[15:0] average
//  cfg_*     in   cfg_valid / cfg_ready   cfg_data[1:0] window_mode
//
//  one sample at a time: accept, index wrap (one more wrap step per window length
//  subtracted), ram read, divide, load; the index needs more wrap steps after a
//  window shrinks
//  reset clears sum, index, fill count and mode; unwritten entries read as zero
//  a waiting result does not block the next sample; the divider result is held
//  until the output register frees up
`default_nettype none

module selectable_window_moving_average
    import swma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input sample stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero fill
    // average stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] average
    // window mode register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data   // [1:0] window_mode
);

    // address, count and sum widths follow the store depth
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SAMPLE_W + CW;

    // window lengths cut to the store depth
    localparam logic [CW-1:0] WIN_SLOW_C = CW'((WIN_SLOW > MAX_WINDOW) ? MAX_WINDOW : WIN_SLOW);
    localparam logic [CW-1:0] WIN_FAST_C = CW'((WIN_FAST > MAX_WINDOW) ? MAX_WINDOW : WIN_FAST);
    localparam logic [CW-1:0] WIN_MID_C  = CW'((WIN_MID > MAX_WINDOW) ? MAX_WINDOW : WIN_MID);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WRAP = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [AW-1:0]       wi_reg, wi_next;       // position of the last write
    logic [SW-1:0]       sum_reg, sum_next;     // sum of every stored entry
    logic [CW-1:0]       fc_reg, fc_next;       // fill count
    logic [CW-1:0]       idx_reg, idx_next;     // index being wrapped
    logic [CW-1:0]       win_reg, win_next;     // window latched per sample
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                ov_reg, ov_next;       // output register full
    logic [AVERAGE_W-1:0] avg_reg, avg_next;

    logic [CW-1:0]       win_sel;
    logic                rd_en;
    logic                wr_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_start;
    logic                div_done;
    logic [SW-1:0]       quotient;
    logic [31:0]         quo_ext;
    logic [AVERAGE_W-1:0] avg_sat;

    // window length from the mode register, unused code means mid
    always_comb
    begin
        case (mode_reg)
            MODE_SLOW: win_sel = WIN_SLOW_C;
            MODE_FAST: win_sel = WIN_FAST_C;
            MODE_MID:  win_sel = WIN_MID_C;
            default:   win_sel = WIN_MID_C;
        endcase
    end

    // saturate the quotient to the output width
    assign quo_ext = 32'(quotient);
    assign avg_sat = (quo_ext > AVG_MAX) ? '1 : quo_ext[AVERAGE_W-1:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = avg_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        wi_next    = wi_reg;
        sum_next   = sum_reg;
        fc_next    = fc_reg;
        idx_next   = idx_reg;
        win_next   = win_reg;
        smp_next   = smp_reg;
        ov_next    = ov_reg;
        avg_next   = avg_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        // result taken downstream
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next   = s_tdata[SAMPLE_W-1:0];
                    idx_next   = CW'(wi_reg) + CW'(1);
                    win_next   = win_sel;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                // index modulo window by repeated subtraction
                if (idx_reg >= win_reg)
                begin
                    idx_next = idx_reg - win_reg;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // old entry leaves the sum, new sample takes its place
                wr_en      = 1'b1;
                sum_next   = sum_reg - SW'(rd_data) + SW'(smp_reg);
                wi_next    = idx_reg[AW-1:0];
                fc_next    = (fc_reg < win_reg) ? fc_reg + CW'(1) : win_reg;
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done && (!ov_reg || m_tready))
                begin
                    avg_next   = avg_sat;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_SLOW;
            wi_reg    <= '0;
            sum_reg   <= '0;
            fc_reg    <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            win_reg   <= WIN_SLOW_C;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            wi_reg    <= wi_next;
            sum_reg   <= sum_next;
            fc_reg    <= fc_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            win_reg   <= win_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        avg_reg <= avg_next;
    end

    // ring store, read in the wrap state and written back in the read state that follows
    swma_store #(
        .DEPTH   (MAX_WINDOW),
        .AW      (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .wr_en   (wr_en),
        .addr    (idx_reg[AW-1:0]),
        .wr_data (smp_reg),
        .rd_data (rd_data)
    );

    // sum over fill count
    swma_div #(
        .SW       (SW),
        .CW       (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fc_next),
        .done     (div_done),
        .quotient (quotient)
    );

`ifndef ASSERT_OFF
    // last write position always lies inside the store
    a_wi_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wi_reg) < MAX_WINDOW)
        else $error("write index beyond store depth");

    // the ram access happens only once the index has wrapped into the window
    a_read_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg < win_reg))
        else $error("store accessed with unwrapped index");

    // a divide never starts with a zero fill count
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (fc_reg != '0))
        else $error("divide with zero fill count");

    // a loaded result comes from a finished divide
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(ov_reg) || (ov_reg && $past(ov_reg && m_tready && state_reg == S_DIV)))
        |-> $past(div_done))
        else $error("result loaded before divide finished");
`endif

endmodule

`default_nettype wire

>>> test/swma_average_checker.sv
// checker for the moving average: watches all channels, predicts each average, compares
`timescale 1ns / 100ps

module swma_average_checker
    import swma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero fill
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [15:0] average
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_data,  // [1:0] window_mode
    output int               failures,
    output int               pending
);

    // shadow copy of the filter state
    logic [SAMPLE_W-1:0]  window_store [MAX_WINDOW];
    int unsigned          ring_pos;
    int unsigned          sample_sum;
    int unsigned          sample_count;
    logic [MODE_W-1:0]    mode_shadow;

    logic [AVERAGE_W-1:0] expected_averages [$];
    logic [AVERAGE_W-1:0] oldest_average;
    int                   k;

    // advance the shadow state by one sample, return the average it yields
    function automatic logic [AVERAGE_W-1:0] next_average(input logic [SAMPLE_W-1:0] value);
        int unsigned win;
        int unsigned quotient;
        case (mode_shadow)
            MODE_SLOW: win = WIN_SLOW;
            MODE_FAST: win = WIN_FAST;
            default:   win = WIN_MID;
        endcase
        if (win > MAX_WINDOW)
        begin
            win = MAX_WINDOW;
        end
        ring_pos = (ring_pos + 1) % win;
        if (ring_pos < MAX_WINDOW)
        begin
            // stale entries outside a shortened window stay in the sum
            sample_sum = sample_sum - window_store[ring_pos] + value;
            window_store[ring_pos] = value;
        end
        if (sample_count < win)
        begin
            sample_count = sample_count + 1;
        end
        else
        begin
            sample_count = win;
        end
        quotient = sample_sum / sample_count;
        if (quotient > AVG_MAX)
        begin
            quotient = AVG_MAX;
        end
        return quotient[AVERAGE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < MAX_WINDOW; k++)
            begin
                window_store[k] = '0;
            end
            ring_pos     = 0;
            sample_sum   = 0;
            sample_count = 0;
            mode_shadow  = MODE_SLOW;
            expected_averages.delete();
            failures     = 0;
            pending      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_averages.size() == 0)
                begin
                    $display("%0t: average transfer %0d with none expected", $time, m_tdata);
                    failures = failures + 1;
                end
                else
                begin
                    oldest_average = expected_averages.pop_front();
                    if (m_tdata !== oldest_average)
                    begin
                        $display("%0t: average mismatch, expected %0d, actual %0d",
                                 $time, oldest_average, m_tdata);
                        failures = failures + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_shadow = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                expected_averages.push_back(next_average(s_tdata[SAMPLE_W-1:0]));
            end
            pending = expected_averages.size();
        end
    end

endmodule

>>> test/tb_selectable_window_moving_average.sv
// testbench top: sample stimulus, window mode writes and the verdict for the moving average
`timescale 1ns / 100ps

module tb_selectable_window_moving_average
    import swma_pkg::*;
();

    // code with no window of its own, falls back to the mid window
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 5000;
    // settle time after the last average
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 16;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [11:0] sample, [15:12] zero fill
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] average
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;   // [1:0] window_mode

    int          failures;
    int          pending;

    // per-phase idling, in percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    selectable_window_moving_average #(
        .MAX_WINDOW (MAX_WINDOW_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    swma_average_checker #(
        .MAX_WINDOW (MAX_WINDOW_DEF)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    // receiver side: random back-pressure on the average stream
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one sample transfer; tvalid stays high when the next one follows without a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - SAMPLE_W){1'b0}}, value};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
    endtask

    // all averages in, then let the block settle; returns on a falling edge
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window_mode(input logic [MODE_W-1:0] mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // sample values: 0 full range, 1 near full scale, 2 full range with extremes mixed in
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
        logic [SAMPLE_W-1:0] value;
        case (style)
            1:       value = SAMPLE_W'($urandom_range(3800, 4095));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = SAMPLE_W'($urandom_range(0, 4095));
                endcase
            end
            default: value = SAMPLE_W'($urandom_range(0, 4095));
        endcase
        return value;
    endfunction

    initial
    begin
        int                p;
        int                i;
        int                count;
        int                style;
        logic [MODE_W-1:0] mode;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: slow window from reset, extremes and alternating bit patterns
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd2048);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd0);
        end_stream();
        wait_drained();

        // fast window: index lies past the short window, fill count capped,
        // stale slow entries stay in the sum
        write_window_mode(MODE_FAST);
        repeat (7) send_sample(12'd4095);
        end_stream();
        wait_drained();

        // unused code behaves as the mid window
        write_window_mode(MODE_UNUSED);
        send_sample(12'd4094);
        send_sample(12'd0);
        send_sample(12'd4095);
        end_stream();
        wait_drained();

        write_window_mode(MODE_MID);
        send_sample(12'd7);
        send_sample(12'd4088);
        end_stream();

        // random phases: window changes keep the state, so stale entries carry over
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       mode = MODE_SLOW;    // fill the long window near full scale
                1:       mode = MODE_FAST;    // stale sum over five saturates the average
                2:       mode = MODE_MID;
                3:       mode = MODE_UNUSED;
                default: mode = MODE_W'($urandom_range(0, 3));
            endcase
            style = (p < 2) ? 1 : $urandom_range(0, 2);
            count = (p == 0) ? 150 : $urandom_range(60, 180);

            wait_drained();
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            write_window_mode(mode);

            for (i = 0; i < count; i++)
            begin
                send_sample(pick_sample(style));
            end
            end_stream();
        end

        wait_drained();
        if (failures == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
